// ----- hw/rtl/lesq_pkg.sv -----
// Package for the largest empty square scan.
// Holds the fixed field widths, reset constants and the result beat type.
// No dependencies; every other file of the block refers to it by scoped names.
package lesq_pkg;

   // Fixed widths of the channel fields.
   localparam int unsigned SCORE_W   = 11;
   localparam int unsigned GRID_W    = 11;
   localparam int unsigned ROW_OUT_W = 10;
   localparam int unsigned COL_OUT_W = 10;

   // Saturation limit of a cell score and reset value of the width register.
   localparam logic [SCORE_W-1:0] SCORE_MAX        = 11'd2047;
   localparam logic [GRID_W-1:0]  GRID_WIDTH_RESET = 11'd1024;

   // One result beat.
   typedef struct packed {
      logic [SCORE_W-1:0]   cell_score;
      logic [SCORE_W-1:0]   best_size;
      logic [ROW_OUT_W-1:0] best_row;
      logic [COL_OUT_W-1:0] best_column;
      logic                 grid_done;
   } rsp_type;

endpackage

// ----- hw/rtl/lesq_ifs.sv -----
// Channel interfaces of the largest empty square scan: cell input, result output
// and the width register write channel. Depends on lesq_pkg for field widths.
interface lesq_req_if;
   logic valid;
   logic ready;
   logic blocked;
   logic last_cell;

   modport source (output valid, output blocked, output last_cell, input ready);
   modport sink (input valid, input blocked, input last_cell, output ready);
   modport monitor (input valid, input blocked, input last_cell, input ready);
endinterface

interface lesq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lesq_pkg::SCORE_W-1:0]     cell_score;
   logic [lesq_pkg::SCORE_W-1:0]     best_size;
   logic [lesq_pkg::ROW_OUT_W-1:0]   best_row;
   logic [lesq_pkg::COL_OUT_W-1:0]   best_column;
   logic                             grid_done;

   modport source (output valid, output cell_score, output best_size, output best_row,
                   output best_column, output grid_done, input ready);
   modport sink (input valid, input cell_score, input best_size, input best_row,
                 input best_column, input grid_done, output ready);
   modport monitor (input valid, input cell_score, input best_size, input best_row,
                    input best_column, input grid_done, input ready);
endinterface

interface lesq_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lesq_pkg::GRID_W-1:0]  grid_width;

   modport source (output valid, output grid_width, input ready);
   modport sink (input valid, input grid_width, output ready);
   modport monitor (input valid, input grid_width, input ready);
endinterface

// ----- hw/rtl/lesq_score_mem.sv -----
// Previous-row score store of the largest empty square scan.
// One write port and one read port with registered read data and a write bypass.
// Depends on lesq_pkg for the score width.
module lesq_score_mem #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [lesq_pkg::SCORE_W-1:0]      wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [lesq_pkg::SCORE_W-1:0]      rd_data
);

   logic [lesq_pkg::SCORE_W-1:0] mem [DEPTH];
   logic [lesq_pkg::SCORE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a write to the same address in the same cycle is forwarded,
   // so the output always shows the current contents of the read address.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lesq_scan_core.sv -----
// Scan state and score logic of the largest empty square scan: position counters,
// left and diagonal scores, best square tracking. Depends on lesq_pkg and drives
// the ports of lesq_score_mem.
module lesq_scan_core #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024,
   localparam int unsigned COL_W      = $clog2(MAX_COLUMNS),
   localparam int unsigned ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lesq_pkg::GRID_W-1:0]   grid_width,
   input  logic                          in_fire,
   input  logic                          blocked,
   input  logic                          last_cell,
   input  logic [lesq_pkg::SCORE_W-1:0]  up_score,
   output logic                          mem_wr_en,
   output logic [COL_W-1:0]              mem_wr_addr,
   output logic [lesq_pkg::SCORE_W-1:0]  mem_wr_data,
   output logic [COL_W-1:0]              mem_rd_addr,
   output lesq_pkg::rsp_type             result
);

   localparam int unsigned CMP_W = (COL_W + 1 > lesq_pkg::GRID_W) ? COL_W + 1
                                                                  : lesq_pkg::GRID_W;
   localparam int unsigned SW    = lesq_pkg::SCORE_W;

   logic [SW-1:0]    left_ff, left_in;
   logic [SW-1:0]    diag_ff, diag_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [SW-1:0]    best_score_ff, best_score_in;
   logic [ROW_W-1:0] best_row_ff, best_row_in;
   logic [COL_W-1:0] best_col_ff, best_col_in;

   logic [CMP_W-1:0] width_raw;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] col_plus;
   logic             row_end;
   logic [ROW_W:0]   row_plus;
   logic [SW-1:0]    min_lu;
   logic [SW-1:0]    min_all;
   logic [SW:0]      score_sum;
   logic [SW-1:0]    score;
   logic             better;
   logic [ROW_W+lesq_pkg::ROW_OUT_W-1:0] row_ext;
   logic [COL_W+lesq_pkg::COL_OUT_W-1:0] col_ext;

   // Effective row length: zero acts as one, anything above the store depth
   // acts as the store depth.
   always_comb begin
      width_raw = CMP_W'(grid_width);
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_COLUMNS)) begin
         width_eff = CMP_W'(MAX_COLUMNS);
      end else begin
         width_eff = width_raw;
      end
      col_plus = CMP_W'(col_ff) + CMP_W'(1);
      row_end  = (col_plus >= width_eff);
      row_plus = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
   end

   // Cell score: least of upper, left and upper-left plus one, saturating.
   always_comb begin
      min_lu    = (left_ff < up_score) ? left_ff : up_score;
      min_all   = (diag_ff < min_lu) ? diag_ff : min_lu;
      score_sum = {1'b0, min_all} + (SW + 1)'(1);
      if (blocked) begin
         score = '0;
      end else if ((row_ff == '0) || (col_ff == '0)) begin
         score = SW'(1);
      end else if (score_sum[SW]) begin
         score = lesq_pkg::SCORE_MAX;
      end else begin
         score = score_sum[SW-1:0];
      end
      better = (score > best_score_ff);
   end

   // Best square after this cell; a tie keeps the earlier square.
   always_comb begin
      best_score_in = better ? score : best_score_ff;
      best_row_in   = better ? row_ff : best_row_ff;
      best_col_in   = better ? col_ff : best_col_ff;
   end

   // Result beat for the cell at the input.
   always_comb begin
      row_ext            = {{lesq_pkg::ROW_OUT_W{1'b0}}, best_row_in};
      col_ext            = {{lesq_pkg::COL_OUT_W{1'b0}}, best_col_in};
      result.cell_score  = score;
      result.best_size   = best_score_in;
      result.best_row    = row_ext[lesq_pkg::ROW_OUT_W-1:0];
      result.best_column = col_ext[lesq_pkg::COL_OUT_W-1:0];
      result.grid_done   = last_cell;
   end

   // Next scan state; the end of the grid clears everything but the store.
   always_comb begin
      left_in = left_ff;
      diag_in = diag_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (in_fire) begin
         if (last_cell) begin
            left_in = '0;
            diag_in = '0;
            row_in  = '0;
            col_in  = '0;
         end else begin
            left_in = score;
            diag_in = up_score;
            if (row_end) begin
               col_in = '0;
               if (row_plus < (ROW_W + 1)'(MAX_ROWS)) begin
                  row_in = row_plus[ROW_W-1:0];
               end
            end else begin
               col_in = col_plus[COL_W-1:0];
            end
         end
      end
   end

   // Store access: write this cell's score, read ahead at the next column.
   always_comb begin
      mem_wr_en   = in_fire;
      mem_wr_addr = col_ff;
      mem_wr_data = score;
      mem_rd_addr = col_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         diag_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         best_score_ff <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else begin
         left_ff <= left_in;
         diag_ff <= diag_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         if (in_fire) begin
            if (last_cell) begin
               best_score_ff <= '0;
               best_row_ff   <= '0;
               best_col_ff   <= '0;
            end else begin
               best_score_ff <= best_score_in;
               best_row_ff   <= best_row_in;
               best_col_ff   <= best_col_in;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/lesq_out_buf.sv -----
// Two-entry result buffer of the largest empty square scan: an output register
// and a skid register, so a stalled receiver does not stop the next cell at once.
// Depends on lesq_pkg for the result beat type.
module lesq_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lesq_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output lesq_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lesq_pkg::rsp_type main_ff, main_in;
   lesq_pkg::rsp_type skid_ff, skid_in;
   logic              in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Refill the output register from the skid entry first, then from the input.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- hw/rtl/largest_empty_square_scan.sv -----
// Largest empty square scan: per-cell maximal square score with best tracking.
// Uses lesq_pkg, lesq_ifs, lesq_score_mem, lesq_scan_core and lesq_out_buf.
//
// Usage:
//   req_ch carries one grid cell per beat in raster order (blocked, last_cell).
//   rsp_ch returns one beat per cell: the cell's score, the best square side
//   so far in this grid and its bottom-right row and column, and grid_done.
//   csr_ch writes grid_width (columns per row); it is always ready and should
//   only be written between grids, with no results outstanding.
// Throughput:
//   Each accepted cell's result is registered in the output or skid register. One
//   cell is taken every cycle while the skid register is empty; the loop through the
//   left score and the previous-row store read (read ahead one column) allows it.
// Reset:
//   Clears the scan position, scores and best square and sets grid_width to
//   1024. The previous-row store is not cleared; the first row ignores what it reads.
// Stall:
//   When rsp_ch.ready is low one further cell is held in a skid register;
//   after that req_ch.ready stays low until the cycle after the receiver takes a beat.
// After a cell with last_cell set, all scan state clears for the next grid.
module largest_empty_square_scan #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   lesq_req_if.sink    req_ch,
   lesq_rsp_if.source  rsp_ch,
   lesq_csr_if.sink    csr_ch
);

   localparam int unsigned COL_W = $clog2(MAX_COLUMNS);

   logic [lesq_pkg::GRID_W-1:0]  grid_width_ff;
   logic [lesq_pkg::GRID_W-1:0]  grid_width_in;
   logic                         in_ready;
   logic                         in_fire;
   logic [lesq_pkg::SCORE_W-1:0] up_score;
   logic                         mem_wr_en;
   logic [COL_W-1:0]             mem_wr_addr;
   logic [lesq_pkg::SCORE_W-1:0] mem_wr_data;
   logic [COL_W-1:0]             mem_rd_addr;
   lesq_pkg::rsp_type            result;
   lesq_pkg::rsp_type            out_data;

   // Width register.
   assign csr_ch.ready  = 1'b1;
   assign grid_width_in = csr_ch.valid ? csr_ch.grid_width : grid_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= lesq_pkg::GRID_WIDTH_RESET;
      end else begin
         grid_width_ff <= grid_width_in;
      end
   end

   // Input handshake.
   assign req_ch.ready = in_ready;
   assign in_fire      = req_ch.valid && in_ready;

   lesq_score_mem #(
      .DEPTH (MAX_COLUMNS)
   ) u_score_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (up_score)
   );

   lesq_scan_core #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_scan_core (
      .clock       (clock),
      .reset       (reset),
      .grid_width  (grid_width_ff),
      .in_fire     (in_fire),
      .blocked     (req_ch.blocked),
      .last_cell   (req_ch.last_cell),
      .up_score    (up_score),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   lesq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (in_ready),
      .in_data   (result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   // Result fields.
   assign rsp_ch.cell_score  = out_data.cell_score;
   assign rsp_ch.best_size   = out_data.best_size;
   assign rsp_ch.best_row    = out_data.best_row;
   assign rsp_ch.best_column = out_data.best_column;
   assign rsp_ch.grid_done   = out_data.grid_done;

endmodule

// ----- hw/rtl/lesq_checker.sv -----
// Port-level checks of the largest empty square scan, attached by bind.
// Depends on lesq_pkg for field widths and on the top level largest_empty_square_scan.
module lesq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lesq_pkg::SCORE_W-1:0]     rsp_cell_score,
   input logic [lesq_pkg::SCORE_W-1:0]     rsp_best_size,
   input logic [lesq_pkg::ROW_OUT_W-1:0]   rsp_best_row,
   input logic [lesq_pkg::COL_OUT_W-1:0]   rsp_best_column,
   input logic                             rsp_grid_done
);

   // A stalled result beat holds its valid, cell score, best size and grid_done.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_cell_score) && $stable(rsp_best_size)
          && $stable(rsp_grid_done)))
      else $error("result beat changed while stalled");

   // The best square is never smaller than the cell just scored.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_size >= rsp_cell_score))
      else $error("best size below cell score");

   // No best square means no corner position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_best_size == '0)) |->
         ((rsp_best_row == '0) && (rsp_best_column == '0)))
      else $error("corner position set with no square found");

   // A result beat only follows an accepted cell or a held beat.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(req_valid && req_ready))
      else $error("result beat without an accepted cell");

endmodule

bind largest_empty_square_scan lesq_checker u_lesq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_cell_score  (rsp_ch.cell_score),
   .rsp_best_size   (rsp_ch.best_size),
   .rsp_best_row    (rsp_ch.best_row),
   .rsp_best_column (rsp_ch.best_column),
   .rsp_grid_done   (rsp_ch.grid_done)
);

// ----- verif/largest_empty_square_scan_tb.sv -----
// Self-checking testbench for the largest empty square scan.
// Needs lesq_pkg, the lesq channel interfaces and the block itself; nothing else.
// Every result beat is checked field by field against a typed or predicted beat.
module largest_empty_square_scan_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_COLUMNS = 1024;
   localparam int unsigned MAX_ROWS    = 1024;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_CELLS = 700;

   typedef logic [lesq_pkg::GRID_W-1:0]    width_type;
   typedef logic [lesq_pkg::SCORE_W-1:0]   score_type;
   typedef logic [lesq_pkg::ROW_OUT_W-1:0] row_pos_type;
   typedef logic [lesq_pkg::COL_OUT_W-1:0] col_pos_type;

   // One row of the directed walk: an optional width write, then one cell.
   typedef struct {
      bit                set_width;
      width_type         width;
      logic              blocked;
      logic              last_cell;
      bit                typed;
      lesq_pkg::rsp_type expected;
   } cell_step_type;

   // What the sender knows about a cell before it is accepted.
   typedef struct {
      bit                typed;
      lesq_pkg::rsp_type value;
   } cell_note_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lesq_req_if req_ch ();
   lesq_rsp_if rsp_ch ();
   lesq_csr_if csr_ch ();

   largest_empty_square_scan #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state, kept beside the block's own.
   width_type   grid_width_reg = lesq_pkg::GRID_WIDTH_RESET;
   score_type   row_scores [MAX_COLUMNS] = '{default: '0};
   score_type   left_side    = '0;
   score_type   corner_side  = '0;
   int unsigned scan_row     = 0;
   int unsigned scan_col     = 0;
   score_type   best_side    = '0;
   row_pos_type best_row_pos = '0;
   col_pos_type best_col_pos = '0;

   cell_note_type     cell_notes [$];
   lesq_pkg::rsp_type awaited_beats [$];
   int unsigned mismatch_count = 0;
   int unsigned beats_checked  = 0;
   int unsigned grids_closed   = 0;
   int unsigned largest_side   = 0;
   int unsigned cycle_count    = 0;
   bit          steady_flow    = 1'b0;

   // Score one cell as the block should, and advance the scan position.
   function automatic lesq_pkg::rsp_type score_cell(input logic is_blocked,
                                                    input logic is_last);
      int unsigned       cols;
      int unsigned       col;
      int unsigned       row;
      int unsigned       up;
      int unsigned       side;
      lesq_pkg::rsp_type beat;
      cols = (grid_width_reg == '0) ? 1 : int'(grid_width_reg);
      if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
      col = (scan_col >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : scan_col;
      row = scan_row;
      up = row_scores[col];

      if (is_blocked) begin
         side = 0;
      end else if (row == 0 || col == 0) begin
         side = 1;
      end else begin
         side = up;
         if (left_side < side) side = left_side;
         if (corner_side < side) side = corner_side;
         side = side + 1;
         if (side > lesq_pkg::SCORE_MAX) side = lesq_pkg::SCORE_MAX;
      end

      // Only a strictly larger square takes over, so ties keep the earlier corner.
      if (side > best_side) begin
         best_side = score_type'(side);
         best_row_pos = row_pos_type'(row);
         best_col_pos = col_pos_type'(col);
      end

      row_scores[col] = score_type'(side);
      corner_side = score_type'(up);
      left_side = score_type'(side);

      // A column at or past the last one closes the row; rows saturate.
      if (col + 1 >= cols) begin
         scan_col = 0;
         if (row + 1 < MAX_ROWS) scan_row = row + 1;
      end else begin
         scan_col = col + 1;
      end

      beat.cell_score = score_type'(side);
      beat.best_size = best_side;
      beat.best_row = best_row_pos;
      beat.best_column = best_col_pos;
      beat.grid_done = is_last;

      if (is_last) begin
         left_side = '0;
         corner_side = '0;
         scan_row = 0;
         scan_col = 0;
         best_side = '0;
         best_row_pos = '0;
         best_col_pos = '0;
      end
      return beat;
   endfunction

   // Watch all three channels: predict on accepted cells, check result beats.
   always @(posedge clock) begin : scoreboard
      cell_note_type     note;
      lesq_pkg::rsp_type predicted;
      lesq_pkg::rsp_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) grid_width_reg = csr_ch.grid_width;

         if (req_ch.valid && req_ch.ready) begin
            note = cell_notes.pop_front();
            predicted = score_cell(req_ch.blocked, req_ch.last_cell);
            awaited_beats.push_back(note.typed ? note.value : predicted);
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_beats.size() == 0) begin
               $error("result beat arrived with no cell waiting for it");
               mismatch_count++;
            end else begin
               want = awaited_beats.pop_front();
               beats_checked++;
               if (rsp_ch.grid_done) grids_closed++;
               if (rsp_ch.best_size > largest_side) largest_side = rsp_ch.best_size;
               if (rsp_ch.cell_score !== want.cell_score) begin
                  $error("cell_score: expected %0d, got %0d", want.cell_score,
                         rsp_ch.cell_score);
                  mismatch_count++;
               end
               if (rsp_ch.best_size !== want.best_size) begin
                  $error("best_size: expected %0d, got %0d", want.best_size,
                         rsp_ch.best_size);
                  mismatch_count++;
               end
               if (rsp_ch.best_row !== want.best_row) begin
                  $error("best_row: expected %0d, got %0d", want.best_row, rsp_ch.best_row);
                  mismatch_count++;
               end
               if (rsp_ch.best_column !== want.best_column) begin
                  $error("best_column: expected %0d, got %0d", want.best_column,
                         rsp_ch.best_column);
                  mismatch_count++;
               end
               if (rsp_ch.grid_done !== want.grid_done) begin
                  $error("grid_done: expected %0d, got %0d", want.grid_done,
                         rsp_ch.grid_done);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver back-pressure: drop ready about a third of the time.
   always @(posedge clock) begin
      rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 32);
   end

   // Hard stop for a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one cell and hold it until the block takes the beat, then maybe idle.
   task automatic send_cell(input logic is_blocked, input logic is_last, input bit typed,
                            input lesq_pkg::rsp_type expected);
      cell_note_type note;
      note.typed = typed;
      note.value = expected;
      cell_notes.push_back(note);
      req_ch.blocked <= is_blocked;
      req_ch.last_cell <= is_last;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if (!steady_flow && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (!steady_flow && $urandom_range(99) < 32);
      end
   endtask

   // Stop sending and wait until every predicted beat has come back.
   task automatic wait_for_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_beats.size() != 0 || cell_notes.size() != 0) @(posedge clock);
   endtask

   // The width register is only written with nothing in flight.
   task automatic write_grid_width(input width_type cols);
      wait_for_quiet();
      csr_ch.grid_width <= cols;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Directed walk: reset behaviour, width extremes, a small grid with a tie and a
   // hole, and a width narrowed partway along a row.
   cell_step_type directed_cells [24] = '{
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b1, {11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
      '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, {11'd0, 11'd1, 10'd0, 10'd0, 1'b1}},
      '{1'b1, 11'd0,    1'b1, 1'b0, 1'b1, {11'd0, 11'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b1, {11'd1, 11'd1, 10'd1, 10'd0, 1'b0}},
      '{1'b0, 11'd0,    1'b0, 1'b1, 1'b0, '0},
      '{1'b1, 11'd3,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b1, 1'b0, '0},
      '{1'b1, 11'd1024, 1'b0, 1'b0, 1'b1, {11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
      '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, {11'd0, 11'd1, 10'd0, 10'd0, 1'b1}},
      '{1'b1, 11'd6,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b1, 11'd2,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 11'd0,    1'b0, 1'b1, 1'b0, '0}
   };

   // Stimulus and the end of the run.
   initial begin
      int unsigned random_cells;
      int unsigned pick;
      int unsigned cols;
      int unsigned live_cols;
      int unsigned cells;
      int unsigned wall_odds;
      int unsigned narrow_at;

      req_ch.valid = 1'b0;
      req_ch.blocked = 1'b0;
      req_ch.last_cell = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.grid_width = '0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cells[i]) begin
         if (directed_cells[i].set_width) write_grid_width(directed_cells[i].width);
         send_cell(directed_cells[i].blocked, directed_cells[i].last_cell,
                   directed_cells[i].typed, directed_cells[i].expected);
      end

      // An over-range width acts as the full 1024 columns, so a short grid stays on
      // its first row.
      write_grid_width(11'd2047);
      for (int n = 0; n < 16; n++) begin
         send_cell($urandom_range(99) < 5, n == 15, 1'b0, '0);
      end

      // Random grids: mostly small widths, varied obstacle density, some grids cut
      // short and some narrowed partway through. Grids in the steady window are
      // full 12 by 10 grids sent with no idling on either side.
      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         steady_flow = (random_cells >= 250 && random_cells < 430);
         pick = $urandom_range(19);
         if (pick == 0) cols = 1;
         else if (pick == 1) cols = 1024;
         else if (pick == 2) cols = 0;
         else cols = $urandom_range(2, 12);
         if (steady_flow) cols = 12;
         write_grid_width(width_type'(cols));
         live_cols = (cols == 0) ? 1 : cols;

         if (cols == 1024) cells = $urandom_range(3, 20);
         else cells = live_cols * $urandom_range(1, 10);
         if (steady_flow) cells = 120;
         else if ($urandom_range(4) == 0) cells = $urandom_range(1, cells);
         wall_odds = $urandom_range(45);
         narrow_at = cells;
         if (!steady_flow && $urandom_range(5) == 0 && live_cols > 1 && cells > 1) begin
            narrow_at = $urandom_range(1, cells - 1);
         end

         for (int n = 0; n < cells; n++) begin
            if (n == narrow_at) begin
               live_cols = $urandom_range(1, live_cols);
               write_grid_width(width_type'(live_cols));
            end
            send_cell($urandom_range(99) < wall_odds, n == cells - 1, 1'b0, '0);
         end
         random_cells += cells;
      end
      steady_flow = 1'b0;

      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (awaited_beats.size() != 0) begin
         $error("%0d predicted result beats never arrived", awaited_beats.size());
         mismatch_count++;
      end

      $display("Checked %0d result beats over %0d grids, widths 0 to 2047 with narrowing",
               beats_checked, grids_closed);
      $display("inside a grid, stalls on both sides and an unbroken stretch; largest side %0d.",
               largest_side);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
